// ===== hdl/bls_pkg.sv =====
// Shared types, constants and codes for the bounded LIFO stack.
// No dependencies; every other file of the block refers to this package.
`default_nettype none

package bls_pkg;

  localparam int DEPTH       = 8;
  localparam int PTR_W       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W       = ($clog2(DEPTH + 1) > 4) ? $clog2(DEPTH + 1) : 4;
  localparam int WORD_W      = 32;
  localparam int CMD_W       = 3;
  localparam int CAP_W       = 4;
  localparam int STAT_W      = 2;
  localparam int OUT_CNT_W   = 4;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;
  localparam int APB_AW      = 3;
  localparam int APB_DW      = 32;

  // register map: capacity_limit is the only register, at byte address 0
  localparam logic REG_CAP_SEL = 1'b0;
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(8);

  // command codes as they arrive on the input channel
  localparam logic [CMD_W-1:0] CMD_PUSH   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_POP    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_PEEK   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_STATUS = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DUMP   = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [STAT_W-1:0] ST_UNDERFLOW = 2'd2;

  typedef enum logic [2:0] {
    OP_PUSH,
    OP_POP,
    OP_PEEK,
    OP_STATUS,
    OP_DUMP
  } op_t;

  typedef enum logic {
    BK_RUN,
    BK_DUMP
  } bk_state_t;

  typedef struct packed {
    logic [CMD_W-1:0]         command;
    logic signed [WORD_W-1:0] push_value;
  } in_item_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] data_value;
    logic [STAT_W-1:0]        status;
    logic                     full_flag;
    logic                     empty_flag;
    logic [OUT_CNT_W-1:0]     entry_count;
    logic                     last_of_run;
  } out_item_t;

  // decoded operation as it travels from the front end to the back end
  typedef struct packed {
    op_t               op;
    logic [WORD_W-1:0] value;
  } work_t;

  // handshake bundle of the work queue towards the back end
  typedef struct packed {
    logic  valid;
    work_t item;
  } work_req_t;

endpackage

`default_nettype wire

// ===== hdl/bls_front.sv =====
// Front end: accepts input transactions and decodes the command into an op.
// Depends on bls_pkg.
`default_nettype none

module bls_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire bls_pkg::in_item_t in_item,
  output logic                   wk_valid,
  input  wire logic              wk_ready,
  output bls_pkg::work_t         wk_item
);

  logic           vld_r;
  logic           vld_nxt;
  bls_pkg::work_t item_r;
  bls_pkg::op_t   op_dec;

  always_comb begin
    unique case (in_item.command)
      bls_pkg::CMD_PUSH:   op_dec = bls_pkg::OP_PUSH;
      bls_pkg::CMD_POP:    op_dec = bls_pkg::OP_POP;
      bls_pkg::CMD_PEEK:   op_dec = bls_pkg::OP_PEEK;
      bls_pkg::CMD_STATUS: op_dec = bls_pkg::OP_STATUS;
      bls_pkg::CMD_DUMP:   op_dec = bls_pkg::OP_DUMP;
      default:             op_dec = bls_pkg::OP_STATUS; // undefined codes query status
    endcase
  end

  assign in_ready = !vld_r || wk_ready;
  assign vld_nxt  = (in_valid && in_ready) || (vld_r && !wk_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r.op    <= op_dec;
      item_r.value <= in_item.push_value;
    end
  end

  assign wk_valid = vld_r;
  assign wk_item  = item_r;

endmodule

`default_nettype wire

// ===== hdl/bls_queue.sv =====
// Two-entry work queue between front end and back end.
// Depends on bls_pkg.
`default_nettype none

module bls_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            wr_valid,
  output logic                 wr_ready,
  input  wire bls_pkg::work_t  wr_item,
  output bls_pkg::work_req_t   rd_req,
  input  wire logic            rd_pop
);

  bls_pkg::work_t                   slot_r [bls_pkg::QUEUE_DEPTH];
  logic [bls_pkg::QPTR_W-1:0]       wr_ptr_r;
  logic [bls_pkg::QPTR_W-1:0]       wr_ptr_nxt;
  logic [bls_pkg::QPTR_W-1:0]       rd_ptr_r;
  logic [bls_pkg::QPTR_W-1:0]       rd_ptr_nxt;
  logic [bls_pkg::QCNT_W-1:0]       cnt_r;
  logic [bls_pkg::QCNT_W-1:0]       cnt_nxt;
  logic                             do_wr;
  logic                             do_rd;

  assign wr_ready = (cnt_r != bls_pkg::QCNT_W'(bls_pkg::QUEUE_DEPTH));
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_pop && (cnt_r != '0);

  always_comb begin
    wr_ptr_nxt = do_wr ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_rd ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + bls_pkg::QCNT_W'(do_wr) - bls_pkg::QCNT_W'(do_rd);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slot_r[wr_ptr_r] <= wr_item;
    end
  end

  assign rd_req.valid = (cnt_r != '0);
  assign rd_req.item  = slot_r[rd_ptr_r];

endmodule

`default_nettype wire

// ===== hdl/bls_back.sv =====
// Back end: stack storage, entry count, dump sequencer and result register.
// Depends on bls_pkg.
`default_nettype none

module bls_back (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic [bls_pkg::CAP_W-1:0]   cap_limit,
  input  wire bls_pkg::work_req_t          wk_req,
  output logic                             wk_pop,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output bls_pkg::out_item_t               out_item
);

  logic [bls_pkg::WORD_W-1:0] store_r [bls_pkg::DEPTH];
  logic [bls_pkg::CNT_W-1:0]  cnt_r;
  logic [bls_pkg::CNT_W-1:0]  cnt_nxt;
  logic [bls_pkg::PTR_W-1:0]  idx_r;
  logic [bls_pkg::PTR_W-1:0]  idx_nxt;
  bls_pkg::bk_state_t         state_r;
  bls_pkg::bk_state_t         state_nxt;
  logic                       out_valid_r;
  bls_pkg::out_item_t         out_item_r;
  bls_pkg::out_item_t         res;

  logic [bls_pkg::CNT_W-1:0]  cap_ext;
  logic [bls_pkg::CNT_W-1:0]  cap_eff;
  logic                       can_emit;
  logic                       emit;
  logic                       wr_en;
  logic [bls_pkg::PTR_W-1:0]  top_idx;
  logic [bls_pkg::PTR_W-1:0]  rd_addr;
  logic [bls_pkg::WORD_W-1:0] rd_word;
  logic [bls_pkg::WORD_W-1:0] data;
  logic [bls_pkg::STAT_W-1:0] stat;
  logic                       last;
  logic                       is_full;

  // capacity register clamped to 1..DEPTH
  always_comb begin
    cap_ext = bls_pkg::CNT_W'(cap_limit);
    if (cap_ext == '0) begin
      cap_eff = bls_pkg::CNT_W'(1);
    end else if (cap_ext > bls_pkg::CNT_W'(bls_pkg::DEPTH)) begin
      cap_eff = bls_pkg::CNT_W'(bls_pkg::DEPTH);
    end else begin
      cap_eff = cap_ext;
    end
  end

  assign is_full  = (cnt_r >= cap_eff);
  assign can_emit = !out_valid_r || out_ready;
  // the low count bits wrap to 0 at full depth; minus one then addresses the last slot
  assign top_idx  = cnt_r[bls_pkg::PTR_W-1:0] - 1'b1;
  assign rd_addr  = (state_r == bls_pkg::BK_DUMP) ? idx_r : top_idx;
  assign rd_word  = store_r[rd_addr];

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bls_pkg::BK_RUN: begin
        if (can_emit && wk_req.valid && wk_req.item.op == bls_pkg::OP_DUMP &&
            cnt_r > bls_pkg::CNT_W'(1)) begin
          state_nxt = bls_pkg::BK_DUMP;
        end
      end
      bls_pkg::BK_DUMP: begin
        if (can_emit && idx_r == '0) begin
          state_nxt = bls_pkg::BK_RUN;
        end
      end
      default: state_nxt = bls_pkg::BK_RUN;
    endcase
  end

  always_comb begin
    wk_pop  = 1'b0;
    emit    = 1'b0;
    wr_en   = 1'b0;
    cnt_nxt = cnt_r;
    idx_nxt = idx_r;
    data    = '0;
    stat    = bls_pkg::ST_OK;
    last    = 1'b1;
    unique case (state_r)
      bls_pkg::BK_RUN: begin
        if (can_emit && wk_req.valid) begin
          wk_pop = 1'b1;
          emit   = 1'b1;
          case (wk_req.item.op)
            bls_pkg::OP_PUSH: begin
              if (is_full) begin
                stat = bls_pkg::ST_OVERFLOW;
              end else begin
                wr_en   = 1'b1;
                cnt_nxt = cnt_r + 1'b1;
              end
            end
            bls_pkg::OP_POP: begin
              if (cnt_r == '0) begin
                stat = bls_pkg::ST_UNDERFLOW;
              end else begin
                data    = rd_word;
                cnt_nxt = cnt_r - 1'b1;
              end
            end
            bls_pkg::OP_PEEK: begin
              if (cnt_r == '0) begin
                stat = bls_pkg::ST_UNDERFLOW;
              end else begin
                data = rd_word;
              end
            end
            bls_pkg::OP_DUMP: begin
              if (cnt_r == '0) begin
                stat = bls_pkg::ST_UNDERFLOW;
              end else begin
                data    = rd_word;
                last    = (cnt_r == bls_pkg::CNT_W'(1));
                idx_nxt = top_idx - 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      bls_pkg::BK_DUMP: begin
        if (can_emit) begin
          emit    = 1'b1;
          data    = rd_word;
          last    = (idx_r == '0);
          idx_nxt = idx_r - 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    res.data_value  = data;
    res.status      = stat;
    res.full_flag   = (cnt_nxt >= cap_eff);
    res.empty_flag  = (cnt_nxt == '0);
    res.entry_count = cnt_nxt[bls_pkg::OUT_CNT_W-1:0];
    res.last_of_run = last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bls_pkg::BK_RUN;
      cnt_r       <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      idx_r   <= idx_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_item_r <= res;
    end
    if (wr_en) begin
      store_r[cnt_r[bls_pkg::PTR_W-1:0]] <= wk_req.item.value;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= bls_pkg::CNT_W'(bls_pkg::DEPTH))
    else $error("entry count above depth");

  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (cnt_r == $past(cnt_r) || cnt_r == $past(cnt_r) + 1'b1 ||
                      cnt_r == $past(cnt_r) - 1'b1))
    else $error("entry count moved by more than one");

  a_dump_idx: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == bls_pkg::BK_DUMP |-> bls_pkg::CNT_W'(idx_r) + 1'b1 < cnt_r)
    else $error("dump index outside stored entries");

  a_dump_start: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bls_pkg::BK_RUN && state_nxt == bls_pkg::BK_DUMP) |=>
      (out_valid_r && !out_item_r.last_of_run))
    else $error("dump start marked as last");

  a_dump_hold: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == bls_pkg::BK_DUMP |=> $stable(cnt_r))
    else $error("entry count changed during dump");

endmodule

`default_nettype wire

// ===== hdl/bounded_lifo_stack_core.sv =====
// Top level of the bounded LIFO stack: APB register, front end, queue, back end.
// Depends on bls_pkg, bls_front, bls_queue and bls_back.
//
// Usage: the in_ channel carries one command per transaction (push, pop, peek,
// status, dump; undefined codes act as status). The out_ channel returns one
// result per command, or one per stored entry for a dump, top to bottom, with
// last_of_run set on the final one. Every result carries the count and the
// full and empty flags as they stand after the command.
// A command passes the front-end register and a queue slot to the result
// register. Throughput: one command per cycle while out_ready stays high; a
// dump holds the back end while the single read port returns its entries.
// A two-entry queue parts the decoder from the back end, and the result
// register lets a new command enter while a result waits; when out_ready stays
// low the back end holds its result and the queue and decoder fill, after
// which in_ready drops.
// Reset (rst_n low, synchronous) empties the stack and sets capacity_limit
// to 8; no clearing pass is needed. capacity_limit is written over APB at byte
// address 0; the user must do so while the block is idle; it is not enforced.
`default_nettype none

module bounded_lifo_stack_core (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire bls_pkg::in_item_t            in_item,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output bls_pkg::out_item_t                out_item,
  input  wire logic                         cfg_psel,
  input  wire logic                         cfg_penable,
  input  wire logic                         cfg_pwrite,
  input  wire logic [bls_pkg::APB_AW-1:0]   cfg_paddr,
  input  wire logic [bls_pkg::APB_DW-1:0]   cfg_pwdata,
  output logic [bls_pkg::APB_DW-1:0]        cfg_prdata,
  output logic                              cfg_pready
);

  logic [bls_pkg::CAP_W-1:0] cap_r;
  logic [bls_pkg::CAP_W-1:0] cap_nxt;
  logic                      cap_wr;
  logic                      fe_valid;
  logic                      fe_ready;
  bls_pkg::work_t            fe_item;
  bls_pkg::work_req_t        q_req;
  logic                      q_pop;

  assign cfg_pready = 1'b1;
  assign cap_wr     = cfg_psel && cfg_penable && cfg_pwrite &&
                      (cfg_paddr[bls_pkg::APB_AW-1] == bls_pkg::REG_CAP_SEL);
  assign cap_nxt    = cap_wr ? cfg_pwdata[bls_pkg::CAP_W-1:0] : cap_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= bls_pkg::CAP_RESET;
    end else begin
      cap_r <= cap_nxt;
    end
  end

  always_comb begin
    if (cfg_paddr[bls_pkg::APB_AW-1] == bls_pkg::REG_CAP_SEL) begin
      cfg_prdata = bls_pkg::APB_DW'(cap_r);
    end else begin
      cfg_prdata = '0;
    end
  end

  bls_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .wk_valid (fe_valid),
    .wk_ready (fe_ready),
    .wk_item  (fe_item)
  );

  bls_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (fe_valid),
    .wr_ready (fe_ready),
    .wr_item  (fe_item),
    .rd_req   (q_req),
    .rd_pop   (q_pop)
  );

  bls_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cap_limit (cap_r),
    .wk_req    (q_req),
    .wk_pop    (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire
